### design/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int CH_W     = 8;
    localparam int BORDER_W = 12;

    typedef struct packed {
        logic accept;
        logic rd_fallback;
        logic load_k_fin;
        logic load_k_border;
        logic commit_now;
        logic commit_held;
    } kmp_cmd_t;

    typedef struct packed {
        logic resolved;
        logic out_free;
    } kmp_status_t;

endpackage

`default_nettype wire

### design/kmp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire kmp_pkg::kmp_status_t status,
    output kmp_pkg::kmp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FALL,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.resolved)
                begin
                    if (status.out_free)
                    begin
                        cmd.commit_now = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.load_k_fin = 1'b1;
                        state_next     = S_HOLD;
                    end
                end
                else
                begin
                    state_next = S_FALL;
                end
            end
            S_FALL:
            begin
                cmd.rd_fallback   = 1'b1;
                cmd.load_k_border = 1'b1;
                state_next        = S_EVAL;
            end
            S_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.commit_held = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_fall_returns_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FALL) |=> (state_reg == S_EVAL))
        else $error("fallback step did not return to compare");

    a_no_commit_unresolved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !status.resolved) |-> !(cmd.commit_now || cmd.load_k_fin))
        else $error("commit before the border was resolved");

    a_accept_leads_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_EVAL))
        else $error("accepted beat did not start a compare");
`endif

endmodule

`default_nettype wire

### design/kmp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [kmp_pkg::CH_W-1:0]        ch,
    input  wire logic                            start_req,
    input  wire kmp_pkg::kmp_cmd_t               cmd,
    output kmp_pkg::kmp_status_t                 status,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [kmp_pkg::BORDER_W-1:0]         border,
    output logic                                 overflow
);

    logic [kmp_pkg::CH_W-1:0]     text_mem [kmp_pkg::MAX_LEN];
    logic [kmp_pkg::ADDR_W-1:0]   border_mem [kmp_pkg::MAX_LEN];

    logic [kmp_pkg::CH_W-1:0]     text_q;
    logic [kmp_pkg::ADDR_W-1:0]   border_q;

    logic [kmp_pkg::CH_W-1:0]     ch_reg;
    logic                         start_reg;
    logic [kmp_pkg::ADDR_W-1:0]   k_reg;
    logic [kmp_pkg::ADDR_W-1:0]   k_next;
    logic [kmp_pkg::ADDR_W-1:0]   cur_reg;
    logic [kmp_pkg::LEN_W-1:0]    len_reg;
    logic                         out_valid_reg;
    logic [kmp_pkg::BORDER_W-1:0] border_reg;
    logic                         overflow_reg;

    logic                         first;
    logic                         full;
    logic                         ovf_eff;
    logic                         match;
    logic                         k_zero;
    logic [kmp_pkg::ADDR_W-1:0]   k_fin;
    logic                         commit;
    logic [kmp_pkg::ADDR_W-1:0]   commit_val;
    logic                         wr_en;
    logic [kmp_pkg::ADDR_W-1:0]   wr_addr;
    logic [kmp_pkg::ADDR_W-1:0]   text_rd_addr;
    logic [kmp_pkg::ADDR_W-1:0]   border_rd_addr;

    assign first   = start_reg || (len_reg == '0);
    assign full    = (len_reg == kmp_pkg::LEN_W'(kmp_pkg::MAX_LEN));
    assign ovf_eff = !first && full;
    assign match   = (text_q == ch_reg);
    assign k_zero  = (k_reg == '0);

    always_comb
    begin
        if (first || full)
        begin
            k_fin = '0;
        end
        else if (match)
        begin
            k_fin = k_reg + kmp_pkg::ADDR_W'(1);
        end
        else
        begin
            k_fin = '0;
        end
    end

    assign status.resolved = first || full || match || k_zero;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign commit     = cmd.commit_now || cmd.commit_held;
    assign commit_val = cmd.commit_now ? k_fin : k_reg;
    assign wr_en      = commit && !ovf_eff;
    assign wr_addr    = first ? '0 : len_reg[kmp_pkg::ADDR_W-1:0];

    assign text_rd_addr   = cmd.rd_fallback ? border_q : cur_reg;
    assign border_rd_addr = k_reg - kmp_pkg::ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[wr_addr]   <= ch_reg;
            border_mem[wr_addr] <= first ? '0 : commit_val;
        end
        text_q   <= text_mem[text_rd_addr];
        border_q <= border_mem[border_rd_addr];
    end

    always_comb
    begin
        priority if (cmd.accept)
        begin
            k_next = cur_reg;
        end
        else if (cmd.load_k_border)
        begin
            k_next = border_q;
        end
        else if (cmd.load_k_fin)
        begin
            k_next = k_fin;
        end
        else
        begin
            k_next = k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
        end
        k_reg <= k_next;
        if (commit)
        begin
            border_reg   <= ovf_eff ? '0 : kmp_pkg::BORDER_W'(commit_val);
            overflow_reg <= ovf_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (first)
                begin
                    len_reg <= kmp_pkg::LEN_W'(1);
                    cur_reg <= '0;
                end
                else if (!full)
                begin
                    len_reg <= len_reg + kmp_pkg::LEN_W'(1);
                    cur_reg <= commit_val;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign border    = border_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> status.out_free)
        else $error("result committed while the output register was occupied");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= kmp_pkg::LEN_W'(kmp_pkg::MAX_LEN))
        else $error("stored length exceeds capacity");

    a_border_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) || ({1'b0, cur_reg} < len_reg))
        else $error("current border not below stored length");

    a_store_grows_len: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !first && !full) |=> (len_reg == $past(len_reg) + kmp_pkg::LEN_W'(1)))
        else $error("stored byte did not extend the length");
`endif

endmodule

`default_nettype wire

### design/kmp_prefix_function.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes the Knuth-Morris-Pratt prefix function of a byte string, one beat
// in and one beat out per byte, with start_req opening a new string. A byte
// is resolved without a fallback step when it matches at the current border,
// when the border is empty, on a start byte or on an overflow byte; otherwise
// each fallback step along the stored prefix values adds a border memory read
// followed by a text memory read. A result waiting in the output register
// does not hold up the next byte's compare; the block only waits to commit.
// Up to 4096 bytes per string are kept; further bytes return zero with
// overflow set. The stores need no clearing after reset.
module kmp_prefix_function (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [kmp_pkg::CH_W-1:0]        ch,
    input  wire logic                            start_req,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [kmp_pkg::BORDER_W-1:0]         border,
    output logic                                 overflow
);

    kmp_pkg::kmp_cmd_t    cmd;
    kmp_pkg::kmp_status_t status;

    kmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .start_req (start_req),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .border    (border),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [kmp_pkg::BORDER_W-1:0] border;
        logic                         overflow;
    } border_beat_t;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [kmp_pkg::CH_W-1:0]     ch = '0;
    logic                         start_req = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [kmp_pkg::BORDER_W-1:0] border;
    logic                         overflow;

    logic [kmp_pkg::CH_W-1:0]     str_bytes [kmp_pkg::MAX_LEN];
    logic [kmp_pkg::BORDER_W-1:0] str_borders [kmp_pkg::MAX_LEN];
    logic [kmp_pkg::LEN_W-1:0]    str_len = '0;
    logic [kmp_pkg::ADDR_W-1:0]   last_border = '0;
    border_beat_t                 expected_borders [$];

    int errors = 0;
    bit steady = 1'b0;
    int hold_orders = 0;
    int hold_served = 0;
    int hold_left = 0;

    kmp_prefix_function uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .border    (border),
        .overflow  (overflow)
    );

    always #10 clk = ~clk;

    task automatic report_error(input string what);
        if (errors < 100)
            $display("%0t ns error: %s", $time, what);
        errors++;
    endtask

    // Feeds one accepted byte to the string model and queues the expected beat.
    function automatic void predict_border(input logic [kmp_pkg::CH_W-1:0] c, input logic s);
        border_beat_t               want;
        logic [kmp_pkg::ADDR_W-1:0] k;
        want = '0;
        if (s || str_len == 0)
        begin
            str_bytes[0] = c;
            str_borders[0] = '0;
            str_len = kmp_pkg::LEN_W'(1);
            last_border = '0;
        end
        else if (str_len >= kmp_pkg::MAX_LEN)
        begin
            want.overflow = 1'b1;
        end
        else
        begin
            k = last_border;
            if (k >= str_len)
                k = '0;
            while (k > 0 && str_bytes[k] != c)
                k = (str_borders[k - 1'b1] < k) ? str_borders[k - 1'b1] : '0;
            if (str_bytes[k] == c)
                k = k + 1'b1;
            str_bytes[str_len[kmp_pkg::ADDR_W-1:0]] = c;
            str_borders[str_len[kmp_pkg::ADDR_W-1:0]] = k;
            str_len = str_len + 1'b1;
            last_border = k;
            want.border = k;
        end
        expected_borders.push_back(want);
    endfunction

    task automatic send_byte(input logic [kmp_pkg::CH_W-1:0] c, input logic s);
        while (!steady && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        start_req <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_border(c, s);
    endtask

    always @(posedge clk)
    begin
        if (hold_served != hold_orders)
        begin
            hold_served = hold_orders;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < 37);
        end
    end

    always @(posedge clk)
    begin : check_beats
        border_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_borders.size() == 0)
            begin
                report_error($sformatf("unexpected beat border=%0d overflow=%0b",
                                       border, overflow));
            end
            else
            begin
                want = expected_borders.pop_front();
                if (border !== want.border)
                    report_error($sformatf("border %0d, want %0d", border, want.border));
                if (overflow !== want.overflow)
                    report_error($sformatf("overflow %0b, want %0b", overflow, want.overflow));
            end
        end
    end

    task automatic test_directed();
        logic [kmp_pkg::CH_W-1:0] seq [20] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                                               8'h80, 8'h01, 8'h55, 8'hAA, 8'hAA, 8'h61,
                                               8'h61, 8'h62, 8'h61, 8'h61, 8'h61, 8'h62,
                                               8'h61, 8'h7F};
        bit                       starts [20] = '{0, 0, 0, 0, 0, 0, 0, 1, 1, 1,
                                                  0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        // The first byte after reset carries no start flag and must open a string anyway.
        for (int i = 0; i < 20; i++)
            send_byte(seq[i], starts[i]);
    endtask

    task automatic test_long_fallback();
        // A run of equal bytes builds a deep border, and the odd byte at the end
        // walks the whole fallback chain back to zero.
        send_byte(8'hFF, 1'b1);
        for (int i = 1; i < 120; i++)
            send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic random_strings(input int n_items);
        int                       sent;
        int                       len;
        int                       n_alpha;
        int                       period;
        logic [kmp_pkg::CH_W-1:0] alpha [4];
        logic [kmp_pkg::CH_W-1:0] pattern [8];
        logic [kmp_pkg::CH_W-1:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_byte(kmp_pkg::CH_W'($urandom_range(255)), $urandom_range(9) == 0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
                n_alpha = $urandom_range(1, 4);
                for (int i = 0; i < 4; i++)
                    alpha[i] = kmp_pkg::CH_W'($urandom_range(255));
                period = $urandom_range(1, 8);
                for (int i = 0; i < 8; i++)
                    pattern[i] = alpha[2'($urandom_range(n_alpha - 1))];
                for (int i = 0; i < len; i++)
                begin
                    c = ($urandom_range(9) == 0) ? alpha[2'($urandom_range(n_alpha - 1))]
                                                 : pattern[3'(i % period)];
                    send_byte(c, i == 0 && $urandom_range(4) != 0);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random();
        random_strings(280);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        random_strings(150);
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        // The receiver holds off while beats keep coming, so the block must stall its input.
        hold_orders++;
        random_strings(50);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_fallback();
        test_random();
        test_backpressure();
        test_steady_stream();
        test_random();
        in_valid <= 1'b0;
        while (expected_borders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("kmp_prefix_function: match");
        else
            $display("kmp_prefix_function: mismatch");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("kmp_prefix_function: mismatch");
        $finish;
    end

endmodule
